FILE: sv/ry420_pkg.sv
// Shared types and constants for the RGB to YCbCr 4:2:0 pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package ry420_pkg;

	// Default number of fraction bits in the coefficients
	localparam int COEF_FRAC_BITS_DEF = 16;

	// Component and position widths
	localparam int PIX_W   = 8;
	localparam int POS_W   = 4;

	// Stage load strobes handed from the pipeline control to each channel
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} stage_ld_t;

endpackage

`default_nettype wire

FILE: sv/ry420_chan.sv
// One color channel: constant multiply, sum with offset, round and clamp in three stages.
`timescale 1ns / 1ps
`default_nettype none

module ry420_chan #(
	parameter int          COEF_FRAC_BITS = ry420_pkg::COEF_FRAC_BITS_DEF,
	parameter longint      KR             = 0,
	parameter longint      KG             = 0,
	parameter longint      KB             = 0,
	parameter longint      OFF_INT        = 0
) (
	input  wire                              clk,
	input  wire  ry420_pkg::stage_ld_t       ld,
	input  wire  [ry420_pkg::PIX_W-1:0]      red,
	input  wire  [ry420_pkg::PIX_W-1:0]      green,
	input  wire  [ry420_pkg::PIX_W-1:0]      blue,
	output logic [ry420_pkg::PIX_W-1:0]      res_s3
);

	// Coefficients carry a sign bit and one guard bit above the fraction
	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam int PW    = CW + ry420_pkg::PIX_W + 1;
	localparam int F     = COEF_FRAC_BITS;
	localparam logic signed [CW-1:0] K_R = CW'(KR);
	localparam logic signed [CW-1:0] K_G = CW'(KG);
	localparam logic signed [CW-1:0] K_B = CW'(KB);
	// Offset plus one half for round to nearest, half up
	localparam logic signed [PW-1:0] ACC_C =
		PW'((OFF_INT <<< COEF_FRAC_BITS) + (64'sd1 <<< (COEF_FRAC_BITS - 1)));

	logic signed [PW-1:0] prod_r_s1;
	logic signed [PW-1:0] prod_g_s1;
	logic signed [PW-1:0] prod_b_s1;
	logic signed [PW-1:0] acc_s2;
	logic                 over;

	// Multiply each component by its coefficient
	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			prod_r_s1 <= PW'($signed({1'b0, red}))   * PW'(K_R);
			prod_g_s1 <= PW'($signed({1'b0, green})) * PW'(K_G);
			prod_b_s1 <= PW'($signed({1'b0, blue}))  * PW'(K_B);
		end
	end

	// Sum the products with offset and rounding half
	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			acc_s2 <= prod_r_s1 + prod_g_s1 + prod_b_s1 + ACC_C;
		end
	end

	// Integer part above 255 saturates
	assign over = |acc_s2[PW-2:F+ry420_pkg::PIX_W];

	// Drop the fraction and clamp to 0..255
	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			if (acc_s2[PW-1]) begin
				res_s3 <= '0;
			end else if (over) begin
				res_s3 <= '1;
			end else begin
				res_s3 <= acc_s2[F+ry420_pkg::PIX_W-1:F];
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/rgb_to_ycbcr_420_pixel_core.sv
// Top level of the JFIF RGB to YCbCr 4:2:0 pixel converter.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one RGB pixel word with its
//   row and column inside a 16x16 macroblock. The master channel (m_tvalid, m_tready,
//   m_tdata) returns one word per pixel: clamped Y, Cb and Cr, the chroma keep flag
//   for 4:2:0 decimation, the 8x8 luma block index with the position in it, and the
//   position in the 8x8 chroma block.
//   The word passes three register stages (multiply, sum, round/clamp), and m_tvalid
//   is the valid bit of the last. Throughput is one word per cycle unless stalled;
//   every stage holds a valid bit, and a stage loads whenever it is empty or the
//   stage after it moves, so bubbles close up. When the receiver stalls, the output
//   register holds its word and the stages behind it keep filling until all three are
//   full; then s_tready drops.
//   Reset clears all valid bits; no word is in flight after reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ycbcr_420_pixel_core #(
	parameter int COEF_FRAC_BITS = ry420_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// red[7:0], green[15:8], blue[23:16], pixel_row[27:24], pixel_col[31:28]
	input  wire  [31:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// luma[7:0], chroma_blue[15:8], chroma_red[23:16], chroma_keep[24],
	// luma_block[26:25], block_row[29:27], block_col[32:30], chroma_row[35:33],
	// chroma_col[38:36], zero[39]
	output logic [39:0] m_tdata
);

	// Coefficients rounded from the JFIF constants
	localparam longint F = COEF_FRAC_BITS;
	localparam longint Y_R  = ((64'sd299  <<< F) + 64'sd500)  / 64'sd1000;
	localparam longint Y_G  = ((64'sd587  <<< F) + 64'sd500)  / 64'sd1000;
	localparam longint Y_B  = ((64'sd114  <<< F) + 64'sd500)  / 64'sd1000;
	localparam longint CB_R = ((64'sd1687 <<< F) + 64'sd5000) / 64'sd10000;
	localparam longint CB_G = ((64'sd3313 <<< F) + 64'sd5000) / 64'sd10000;
	localparam longint HALF = ((64'sd5    <<< F) + 64'sd5)    / 64'sd10;
	localparam longint CR_G = ((64'sd4187 <<< F) + 64'sd5000) / 64'sd10000;
	localparam longint CR_B = ((64'sd813  <<< F) + 64'sd5000) / 64'sd10000;

	localparam int PW = ry420_pkg::PIX_W;
	localparam int QW = ry420_pkg::POS_W;

	// Derived position fields: keep, block, block row, block col, chroma row, chroma col
	typedef struct packed {
		logic        keep;
		logic [1:0]  blk;
		logic [2:0]  brow;
		logic [2:0]  bcol;
		logic [2:0]  crow;
		logic [2:0]  ccol;
	} pos_t;

	logic                 vld_s1;
	logic                 vld_s2;
	logic                 vld_s3;
	logic                 rdy1;
	logic                 rdy2;
	logic                 rdy3;
	ry420_pkg::stage_ld_t ld;
	logic [PW-1:0]        red;
	logic [PW-1:0]        green;
	logic [PW-1:0]        blue;
	logic [QW-1:0]        row;
	logic [QW-1:0]        col;
	pos_t                 pos_in;
	pos_t                 pos_s1;
	pos_t                 pos_s2;
	pos_t                 pos_s3;
	logic [PW-1:0]        y_s3;
	logic [PW-1:0]        cb_s3;
	logic [PW-1:0]        cr_s3;

	// Unpack the input word
	assign red   = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign blue  = s_tdata[23:16];
	assign row   = s_tdata[27:24];
	assign col   = s_tdata[31:28];

	// A stage loads when it is empty or its successor moves
	assign rdy3     = ~vld_s3 | m_tready;
	assign rdy2     = ~vld_s2 | rdy3;
	assign rdy1     = ~vld_s1 | rdy2;
	assign s_tready = rdy1;
	assign ld       = '{ld_s1: rdy1, ld_s2: rdy2, ld_s3: rdy3};

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	// Split the macroblock position
	always_comb begin
		pos_in.keep = ~row[0] & ~col[0];
		pos_in.blk  = {row[3], col[3]};
		pos_in.brow = row[2:0];
		pos_in.bcol = col[2:0];
		pos_in.crow = row[3:1];
		pos_in.ccol = col[3:1];
	end

	// Carry the position alongside the arithmetic
	always_ff @(posedge clk) begin
		if (ld.ld_s1) pos_s1 <= pos_in;
		if (ld.ld_s2) pos_s2 <= pos_s1;
		if (ld.ld_s3) pos_s3 <= pos_s2;
	end

	ry420_chan #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.KR             (Y_R),
		.KG             (Y_G),
		.KB             (Y_B),
		.OFF_INT        (0)
	) u_luma (
		.clk    (clk),
		.ld     (ld),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.res_s3 (y_s3)
	);

	ry420_chan #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.KR             (-CB_R),
		.KG             (-CB_G),
		.KB             (HALF),
		.OFF_INT        (128)
	) u_cb (
		.clk    (clk),
		.ld     (ld),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.res_s3 (cb_s3)
	);

	ry420_chan #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.KR             (HALF),
		.KG             (-CR_G),
		.KB             (-CR_B),
		.OFF_INT        (128)
	) u_cr (
		.clk    (clk),
		.ld     (ld),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.res_s3 (cr_s3)
	);

	// Pack the output word
	assign m_tvalid = vld_s3;
	assign m_tdata  = {1'b0, pos_s3.ccol, pos_s3.crow, pos_s3.bcol, pos_s3.brow,
		pos_s3.blk, pos_s3.keep, cr_s3, cb_s3, y_s3};

endmodule

`default_nettype wire

FILE: sv/ry420_checker.sv
// Port-level checks for the RGB to YCbCr 4:2:0 pixel converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ry420_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata
);

	// A stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// With the receiver ready throughout, an accepted word reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("accepted word did not reach the output");

	// Chroma is kept only at even row and column
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24] == (!m_tdata[27] && !m_tdata[30])))
		else $error("chroma keep flag disagrees with position");

	// Chroma position agrees with luma block and block position; the top bit is zero
	a_cpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:33] == m_tdata[29:28]) && (m_tdata[35] == m_tdata[26])
			&& (m_tdata[37:36] == m_tdata[32:31]) && (m_tdata[38] == m_tdata[25])
			&& !m_tdata[39])
		else $error("chroma position disagrees with luma position");

endmodule

bind rgb_to_ycbcr_420_pixel_core ry420_checker u_ry420_checker (.*);

`default_nettype wire

FILE: bench/tb_rgb_to_ycbcr_420_pixel_core.sv
// Self-checking bench for the RGB to YCbCr 4:2:0 pixel converter.
`timescale 1ns / 1ps

module tb_rgb_to_ycbcr_420_pixel_core;

	localparam int FRAC = ry420_pkg::COEF_FRAC_BITS_DEF;

	// Coefficients scaled by 2^FRAC, rounded half up
	localparam longint K_YR  = ((64'sd299 <<< FRAC) + 500) / 1000;
	localparam longint K_YG  = ((64'sd587 <<< FRAC) + 500) / 1000;
	localparam longint K_YB  = ((64'sd114 <<< FRAC) + 500) / 1000;
	localparam longint K_CBR = ((64'sd1687 <<< FRAC) + 5000) / 10000;
	localparam longint K_CBG = ((64'sd3313 <<< FRAC) + 5000) / 10000;
	localparam longint K_HALF_C = ((64'sd5 <<< FRAC) + 5) / 10;
	localparam longint K_CRG = ((64'sd4187 <<< FRAC) + 5000) / 10000;
	localparam longint K_CRB = ((64'sd813 <<< FRAC) + 5000) / 10000;
	localparam longint K_OFS = 64'sd128 <<< FRAC;

	localparam int HOLD_CYCLES = 300;

	// Input word, first field in the highest bits
	typedef struct packed {
		logic [3:0] pixel_col;
		logic [3:0] pixel_row;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_word_t;

	// Output word, first field in the highest bits
	typedef struct packed {
		logic       pad;
		logic [2:0] chroma_col;
		logic [2:0] chroma_row;
		logic [2:0] block_col;
		logic [2:0] block_row;
		logic [1:0] luma_block;
		logic       chroma_keep;
		logic [7:0] chroma_red;
		logic [7:0] chroma_blue;
		logic [7:0] luma;
	} ycc_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	// red[7:0], green[15:8], blue[23:16], pixel_row[27:24], pixel_col[31:28]
	logic [31:0] s_tdata = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	// luma[7:0], chroma_blue[15:8], chroma_red[23:16], chroma_keep[24],
	// luma_block[26:25], block_row[29:27], block_col[32:30], chroma_row[35:33],
	// chroma_col[38:36], zero[39]
	wire  [39:0] m_tdata;

	pixel_word_t pixel_q[$];
	ycc_word_t   ycc_q[$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_go = 1'b0;
	int          hold_left = 0;

	rgb_to_ycbcr_420_pixel_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Round half up, then clamp to the 8-bit range
	function automatic logic [7:0] round_sat(input longint acc);
		longint v;
		v = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	// Converted pixel and its block bookkeeping
	function automatic ycc_word_t predict_ycc(input pixel_word_t px);
		ycc_word_t w;
		longint r, g, b;
		r = longint'(px.red);
		g = longint'(px.green);
		b = longint'(px.blue);
		w.luma        = round_sat(K_YR * r + K_YG * g + K_YB * b);
		w.chroma_blue = round_sat(K_OFS - K_CBR * r - K_CBG * g + K_HALF_C * b);
		w.chroma_red  = round_sat(K_OFS + K_HALF_C * r - K_CRG * g - K_CRB * b);
		w.chroma_keep = ~px.pixel_row[0] & ~px.pixel_col[0];
		w.luma_block  = {px.pixel_row[3], px.pixel_col[3]};
		w.block_row   = px.pixel_row[2:0];
		w.block_col   = px.pixel_col[2:0];
		w.chroma_row  = px.pixel_row[3:1];
		w.chroma_col  = px.pixel_col[3:1];
		w.pad         = 1'b0;
		return w;
	endfunction

	function automatic pixel_word_t mk_pixel(input int r, input int g, input int b,
			input int row, input int col);
		pixel_word_t px;
		px.red       = r[7:0];
		px.green     = g[7:0];
		px.blue      = b[7:0];
		px.pixel_row = row[3:0];
		px.pixel_col = col[3:0];
		return px;
	endfunction

	// Component biased toward the extremes now and then
	function automatic int rand_comp();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return 255;
		return $urandom_range(255);
	endfunction

	function automatic pixel_word_t rand_pixel();
		return mk_pixel(rand_comp(), rand_comp(), rand_comp(),
			$urandom_range(15), $urandom_range(15));
	endfunction

	task automatic cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Feed pending words; hold a word until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				ycc_q.push_back(predict_ycc(pixel_word_t'(s_tdata)));
			if (!s_tvalid || s_tready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Count down a long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Check each output word against the oldest expectation, then pick ready
	always @(posedge clk or negedge arst_n) begin : mon
		ycc_word_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = ycc_word_t'(m_tdata);
				if (ycc_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
				end else begin
					want = ycc_q.pop_front();
					cmp_field("luma", want.luma, got.luma);
					cmp_field("chroma_blue", want.chroma_blue, got.chroma_blue);
					cmp_field("chroma_red", want.chroma_red, got.chroma_red);
					cmp_field("chroma_keep", want.chroma_keep, got.chroma_keep);
					cmp_field("luma_block", want.luma_block, got.luma_block);
					cmp_field("block_row", want.block_row, got.block_row);
					cmp_field("block_col", want.block_col, got.block_col);
					cmp_field("chroma_row", want.chroma_row, got.chroma_row);
					cmp_field("chroma_col", want.chroma_col, got.chroma_col);
					cmp_field("pad", want.pad, got.pad);
				end
			end
			m_tready <= (hold_left == 0) && !hold_go &&
				($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Wait until every queued word has been sent and every result checked
	task automatic wait_drained();
		while (pixel_q.size() != 0 || s_tvalid || ycc_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_random(input int count);
		repeat (count)
			pixel_q.push_back(rand_pixel());
	endtask

	// Stimulus phases
	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: color extremes, clamp corners, block and parity corners
		pixel_q.push_back(mk_pixel(0, 0, 0, 0, 0));
		pixel_q.push_back(mk_pixel(255, 255, 255, 15, 15));
		pixel_q.push_back(mk_pixel(255, 0, 0, 0, 15));
		pixel_q.push_back(mk_pixel(0, 255, 0, 15, 0));
		pixel_q.push_back(mk_pixel(0, 0, 255, 7, 8));
		pixel_q.push_back(mk_pixel(255, 255, 0, 8, 7));
		pixel_q.push_back(mk_pixel(0, 255, 255, 7, 7));
		pixel_q.push_back(mk_pixel(255, 0, 255, 8, 8));
		pixel_q.push_back(mk_pixel(128, 128, 128, 1, 0));
		pixel_q.push_back(mk_pixel(1, 1, 1, 0, 1));
		pixel_q.push_back(mk_pixel(254, 254, 254, 1, 1));
		pixel_q.push_back(mk_pixel(255, 255, 0, 2, 2));
		pixel_q.push_back(mk_pixel(0, 0, 255, 14, 14));
		pixel_q.push_back(mk_pixel(255, 0, 0, 9, 6));
		pixel_q.push_back(mk_pixel(0, 255, 255, 6, 9));
		pixel_q.push_back(mk_pixel(170, 85, 170, 10, 5));
		pixel_q.push_back(mk_pixel(85, 170, 85, 5, 10));
		pixel_q.push_back(mk_pixel(0, 128, 255, 12, 3));
		pixel_q.push_back(mk_pixel(255, 128, 0, 3, 12));
		pixel_q.push_back(mk_pixel(16, 235, 16, 4, 13));
		pixel_q.push_back(mk_pixel(235, 16, 235, 13, 4));
		pixel_q.push_back(mk_pixel(127, 128, 127, 11, 11));
		wait_drained();

		// Random: no idling
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		push_random(256);
		wait_drained();

		// Random: sender mostly idle
		send_idle_pct  = 87;
		recv_stall_pct = 0;
		push_random(256);
		wait_drained();

		// Random: receiver mostly stalling
		send_idle_pct  = 0;
		recv_stall_pct = 87;
		push_random(256);
		wait_drained();

		// Random: both sides idle now and then
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		push_random(256);
		wait_drained();

		// Long receiver hold-off while the sender keeps offering
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go = 1'b1;
		push_random(64);
		@(negedge clk);
		hold_go = 1'b0;
		wait_drained();

		// Random: short bursts at mixed idle rates
		repeat (6) begin
			send_idle_pct  = $urandom_range(90);
			recv_stall_pct = $urandom_range(90);
			push_random(32);
			wait_drained();
		end

		// Let any stray word show up before the verdict
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#3ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
